// File: rtl/smps_pkg.sv
// ----------------------------------------------------------------------------
// Scaled matrix product sum package
// Shared widths and opcodes for the scaled matrix product sum block.
// ----------------------------------------------------------------------------
package smps_pkg;

	localparam int MAX_N_DEF = 8;
	localparam int IDX_W     = 3;
	localparam int ELEM_W    = 16;
	localparam int N_W       = 4;
	localparam int SUM_W     = 22;
	localparam int DIVR_W    = 8;
	localparam int AVG_W     = 17;
	localparam int DOT_W     = 35;
	localparam int PART_W    = 50;
	localparam int PROD_W    = PART_W + AVG_W;
	localparam int ACC_W     = 70;
	localparam int OUT_W     = 64;

	localparam logic [2:0] OP_LOAD_A = 3'd0;
	localparam logic [2:0] OP_LOAD_B = 3'd1;
	localparam logic [2:0] OP_LOAD_C = 3'd2;
	localparam logic [2:0] OP_LOAD_D = 3'd3;
	localparam logic [2:0] OP_LOAD_L = 3'd4;
	localparam logic [2:0] OP_RUN    = 3'd5;

endpackage

// File: rtl/smps_ifs.sv
// ----------------------------------------------------------------------------
// Scaled matrix product sum channels
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface smps_req_if;
	logic                               valid;
	logic                               ready;
	logic [2:0]                         opcode;
	logic [smps_pkg::IDX_W-1:0]         row_index;
	logic [smps_pkg::IDX_W-1:0]         col_index;
	logic signed [smps_pkg::ELEM_W-1:0] elem_value;
	modport source(output valid, opcode, row_index, col_index, elem_value, input ready);
	modport sink(input valid, opcode, row_index, col_index, elem_value, output ready);
endinterface

interface smps_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [smps_pkg::IDX_W-1:0]        out_row;
	logic [smps_pkg::IDX_W-1:0]        out_col;
	logic signed [smps_pkg::OUT_W-1:0] out_value;
	logic                              last;
	modport source(output valid, out_row, out_col, out_value, last, input ready);
	modport sink(input valid, out_row, out_col, out_value, last, output ready);
endinterface

interface smps_cfg_if;
	logic                     valid;
	logic                     ready;
	logic [smps_pkg::N_W-1:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

// File: rtl/scaled_matrix_product_sum.sv
// ----------------------------------------------------------------------------
// Scaled matrix product sum
// Stores five square matrices and emits (lavg*A)*B*C + (bavg*L)*B*D.
// ----------------------------------------------------------------------------
// A load transaction writes one element. A compute transaction runs a
// sequencer around one shared multiplier and a bit-serial divider: it sums B
// and L, computes the two averages, then forms the partial products and
// then the final matrix, with one result transaction per element. An element
// waits on the output only while the previous result is still held in the
// output register. Requests are refused until the last result has been
// loaded into the output register.
module scaled_matrix_product_sum #(
	parameter int MAX_N = smps_pkg::MAX_N_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	smps_req_if.sink   req,
	smps_rsp_if.source rsp,
	smps_cfg_if.sink   cfg
);
	localparam int CELLS  = MAX_N * MAX_N;
	localparam int AW     = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int IW     = smps_pkg::IDX_W;
	localparam int EW     = smps_pkg::ELEM_W;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_S_RD = 5'd1;
	localparam logic [4:0] ST_S_AC = 5'd2;
	localparam logic [4:0] ST_D_L  = 5'd3;
	localparam logic [4:0] ST_D_LW = 5'd4;
	localparam logic [4:0] ST_D_B  = 5'd5;
	localparam logic [4:0] ST_D_BW = 5'd6;
	localparam logic [4:0] ST_P_RD = 5'd7;
	localparam logic [4:0] ST_P_MA = 5'd8;
	localparam logic [4:0] ST_P_ML = 5'd9;
	localparam logic [4:0] ST_P_AC = 5'd10;
	localparam logic [4:0] ST_P_SA = 5'd11;
	localparam logic [4:0] ST_P_SL = 5'd12;
	localparam logic [4:0] ST_P_WR = 5'd13;
	localparam logic [4:0] ST_F_RD = 5'd14;
	localparam logic [4:0] ST_F_MC = 5'd15;
	localparam logic [4:0] ST_F_MD = 5'd16;
	localparam logic [4:0] ST_F_AC = 5'd17;
	localparam logic [4:0] ST_F_OUT = 5'd18;

	logic [4:0]                      state_q;
	logic [smps_pkg::N_W-1:0]        n_used_q;
	logic [smps_pkg::N_W-1:0]        n_eff_q;
	logic [IW-1:0]                   nm1;
	logic [IW-1:0]                   i_q, j_q, k_q;
	logic signed [smps_pkg::SUM_W-1:0] lsum_q, bsum_q;
	logic signed [smps_pkg::AVG_W-1:0] lavg_q, bavg_q;
	logic signed [smps_pkg::DOT_W-1:0] sab_q, slb_q;
	logic signed [smps_pkg::ACC_W-1:0] acc_q;
	logic signed [smps_pkg::PROD_W-1:0] prod_q;
	logic signed [smps_pkg::PART_W-1:0] mul_x;
	logic signed [smps_pkg::AVG_W-1:0]  mul_y;

	logic signed [EW-1:0] mem_a [CELLS];
	logic signed [EW-1:0] mem_b [CELLS];
	logic signed [EW-1:0] mem_c [CELLS];
	logic signed [EW-1:0] mem_d [CELLS];
	logic signed [EW-1:0] mem_l [CELLS];
	logic signed [smps_pkg::PART_W-1:0] mem_pab [CELLS];
	logic signed [smps_pkg::PART_W-1:0] mem_plb [CELLS];
	logic signed [EW-1:0] a_rd_q, b_rd_q, c_rd_q, d_rd_q, l_rd_q;
	logic signed [smps_pkg::PART_W-1:0] pab_rd_q, plb_rd_q;

	logic [AW-1:0] addr_ij, addr_ik, addr_kj, addr_ld;
	logic          ld_ok;
	logic          req_fire;
	logic          div_start, div_done;
	logic [smps_pkg::SUM_W-1:0]  div_dvd, div_quo;
	logic [smps_pkg::DIVR_W-1:0] div_dvr;
	logic signed [smps_pkg::AVG_W-1:0] avg_new;
	logic          div_neg;
	logic          out_vld_q;
	logic [IW-1:0] out_row_q, out_col_q;
	logic signed [smps_pkg::OUT_W-1:0] out_val_q;
	logic          out_last_q;
	logic signed [smps_pkg::OUT_W-1:0] sat_val;
	logic          last_elem;
	logic          out_free;
	logic          sum_phase;

	assign nm1       = IW'(n_eff_q - 1'b1);
	assign addr_ij   = AW'(int'(i_q) * MAX_N + int'(j_q));
	assign addr_ik   = AW'(int'(i_q) * MAX_N + int'(k_q));
	assign addr_kj   = AW'(int'(k_q) * MAX_N + int'(j_q));
	assign addr_ld   = AW'(int'(req.row_index) * MAX_N + int'(req.col_index));
	assign ld_ok     = (int'(req.row_index) < MAX_N) && (int'(req.col_index) < MAX_N);
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign sum_phase = (state_q == ST_S_RD) || (state_q == ST_S_AC);
	assign last_elem = (i_q == nm1) && (j_q == nm1);
	assign out_free  = !out_vld_q || rsp.ready;

	always_ff @(posedge clk) begin
		if (req_fire && ld_ok) begin
			case (req.opcode)
				smps_pkg::OP_LOAD_A: mem_a[addr_ld] <= req.elem_value;
				smps_pkg::OP_LOAD_B: mem_b[addr_ld] <= req.elem_value;
				smps_pkg::OP_LOAD_C: mem_c[addr_ld] <= req.elem_value;
				smps_pkg::OP_LOAD_D: mem_d[addr_ld] <= req.elem_value;
				smps_pkg::OP_LOAD_L: mem_l[addr_ld] <= req.elem_value;
				default: ;
			endcase
		end
		a_rd_q <= mem_a[addr_ik];
		b_rd_q <= mem_b[sum_phase ? addr_ij : addr_kj];
		c_rd_q <= mem_c[addr_kj];
		d_rd_q <= mem_d[addr_kj];
		l_rd_q <= mem_l[sum_phase ? addr_ij : addr_ik];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_P_SL) begin
			mem_pab[addr_ij] <= prod_q[smps_pkg::PART_W-1:0];
		end
		if (state_q == ST_P_WR) begin
			mem_plb[addr_ij] <= prod_q[smps_pkg::PART_W-1:0];
		end
		pab_rd_q <= mem_pab[addr_ik];
		plb_rd_q <= mem_plb[addr_ik];
	end

	always_comb begin
		mul_x = '0;
		mul_y = '0;
		case (state_q)
			ST_P_MA: begin
				mul_x = smps_pkg::PART_W'(a_rd_q);
				mul_y = smps_pkg::AVG_W'(b_rd_q);
			end
			ST_P_ML: begin
				mul_x = (k_q <= i_q) ? smps_pkg::PART_W'(l_rd_q) : '0;
				mul_y = smps_pkg::AVG_W'(b_rd_q);
			end
			ST_P_SA: begin
				mul_x = smps_pkg::PART_W'(sab_q);
				mul_y = lavg_q;
			end
			ST_P_SL: begin
				mul_x = smps_pkg::PART_W'(slb_q);
				mul_y = bavg_q;
			end
			ST_F_MC: begin
				mul_x = pab_rd_q;
				mul_y = smps_pkg::AVG_W'(c_rd_q);
			end
			ST_F_MD: begin
				mul_x = plb_rd_q;
				mul_y = smps_pkg::AVG_W'(d_rd_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_x * mul_y;
	end

	assign div_neg   = (state_q == ST_D_LW) ? lsum_q[smps_pkg::SUM_W-1]
	                                        : bsum_q[smps_pkg::SUM_W-1];
	assign div_start = (state_q == ST_D_L) || (state_q == ST_D_B);
	assign div_dvd   = (state_q == ST_D_L) ? (lsum_q[smps_pkg::SUM_W-1] ? -lsum_q : lsum_q)
	                                       : (bsum_q[smps_pkg::SUM_W-1] ? -bsum_q : bsum_q);
	assign div_dvr   = {{(smps_pkg::DIVR_W-smps_pkg::N_W){1'b0}}, n_eff_q} *
	                   {{(smps_pkg::DIVR_W-smps_pkg::N_W){1'b0}}, n_eff_q};
	assign avg_new   = div_neg ? -smps_pkg::AVG_W'(div_quo) : smps_pkg::AVG_W'(div_quo);

	smps_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvr),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		if (acc_q[smps_pkg::ACC_W-1:smps_pkg::OUT_W-1] == '0 ||
		    acc_q[smps_pkg::ACC_W-1:smps_pkg::OUT_W-1] == '1) begin
			sat_val = acc_q[smps_pkg::OUT_W-1:0];
		end else if (acc_q[smps_pkg::ACC_W-1]) begin
			sat_val = {1'b1, {(smps_pkg::OUT_W-1){1'b0}}};
		end else begin
			sat_val = {1'b0, {(smps_pkg::OUT_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			n_used_q  <= smps_pkg::N_W'(MAX_N);
			n_eff_q   <= smps_pkg::N_W'(MAX_N);
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				n_used_q <= cfg.data;
			end
			if (out_vld_q && rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire && req.opcode == smps_pkg::OP_RUN) begin
						if (n_used_q == '0) begin
							n_eff_q <= smps_pkg::N_W'(1);
						end else if (int'(n_used_q) > MAX_N) begin
							n_eff_q <= smps_pkg::N_W'(MAX_N);
						end else begin
							n_eff_q <= n_used_q;
						end
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= ST_S_RD;
					end
				end
				ST_S_RD: state_q <= ST_S_AC;
				ST_S_AC: begin
					if (j_q == nm1) begin
						j_q <= '0;
						if (i_q == nm1) begin
							i_q     <= '0;
							state_q <= ST_D_L;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= ST_S_RD;
						end
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_S_RD;
					end
				end
				ST_D_L: state_q <= ST_D_LW;
				ST_D_LW: begin
					if (div_done) begin
						state_q <= ST_D_B;
					end
				end
				ST_D_B: state_q <= ST_D_BW;
				ST_D_BW: begin
					if (div_done) begin
						state_q <= ST_P_RD;
					end
				end
				ST_P_RD: state_q <= ST_P_MA;
				ST_P_MA: state_q <= ST_P_ML;
				ST_P_ML: state_q <= ST_P_AC;
				ST_P_AC: begin
					if (k_q == nm1) begin
						k_q     <= '0;
						state_q <= ST_P_SA;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_P_RD;
					end
				end
				ST_P_SA: state_q <= ST_P_SL;
				ST_P_SL: state_q <= ST_P_WR;
				ST_P_WR: begin
					state_q <= ST_P_RD;
					if (j_q == nm1) begin
						j_q <= '0;
						if (i_q == nm1) begin
							i_q     <= '0;
							state_q <= ST_F_RD;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_F_RD: state_q <= ST_F_MC;
				ST_F_MC: state_q <= ST_F_MD;
				ST_F_MD: state_q <= ST_F_AC;
				ST_F_AC: begin
					if (k_q == nm1) begin
						k_q     <= '0;
						state_q <= ST_F_OUT;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_F_RD;
					end
				end
				ST_F_OUT: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
						state_q   <= ST_F_RD;
						if (j_q == nm1) begin
							j_q <= '0;
							if (i_q == nm1) begin
								i_q     <= '0;
								state_q <= ST_IDLE;
							end else begin
								i_q <= i_q + 1'b1;
							end
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				lsum_q <= '0;
				bsum_q <= '0;
			end
			ST_S_AC: begin
				bsum_q <= bsum_q + smps_pkg::SUM_W'(b_rd_q);
				if (j_q < i_q) begin
					lsum_q <= lsum_q + smps_pkg::SUM_W'(l_rd_q);
				end
			end
			ST_D_LW: begin
				if (div_done) begin
					lavg_q <= avg_new;
				end
			end
			ST_D_BW: begin
				if (div_done) begin
					bavg_q <= avg_new;
					sab_q  <= '0;
					slb_q  <= '0;
				end
			end
			ST_P_ML: sab_q <= sab_q + smps_pkg::DOT_W'(prod_q);
			ST_P_AC: slb_q <= slb_q + smps_pkg::DOT_W'(prod_q);
			ST_P_WR: begin
				sab_q <= '0;
				slb_q <= '0;
				acc_q <= '0;
			end
			ST_F_MD: acc_q <= acc_q + smps_pkg::ACC_W'(prod_q);
			ST_F_AC: acc_q <= acc_q + smps_pkg::ACC_W'(prod_q);
			ST_F_OUT: begin
				if (out_free) begin
					out_row_q  <= i_q;
					out_col_q  <= j_q;
					out_val_q  <= sat_val;
					out_last_q <= last_elem;
					acc_q      <= '0;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid     = out_vld_q;
	assign rsp.out_row   = out_row_q;
	assign rsp.out_col   = out_col_q;
	assign rsp.out_value = out_val_q;
	assign rsp.last      = out_last_q;

	a_last_diag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.last |-> rsp.out_row == rsp.out_col)
		else $error("Final result is not on the diagonal.");

	a_last_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.ready && rsp.last |=> !rsp.valid)
		else $error("Result transaction follows the final element.");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.out_row <= nm1) && (rsp.out_col <= nm1))
		else $error("Result index outside the active matrix size.");

endmodule

// File: rtl/smps_div.sv
// ----------------------------------------------------------------------------
// Scaled matrix product sum divider
// Restoring unsigned divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smps_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [smps_pkg::SUM_W-1:0]       dividend,
	input  logic [smps_pkg::DIVR_W-1:0]      divisor,
	output logic                             done,
	output logic [smps_pkg::SUM_W-1:0]       quotient
);
	localparam int CNT_W = $clog2(smps_pkg::SUM_W + 1);

	logic [CNT_W-1:0]              cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [smps_pkg::DIVR_W-1:0]   rem_q;
	logic [smps_pkg::SUM_W-1:0]    quo_q;
	logic [smps_pkg::DIVR_W:0]     shifted;
	logic [smps_pkg::DIVR_W:0]     trial;

	assign shifted = {rem_q, quo_q[smps_pkg::SUM_W-1]};
	assign trial   = shifted - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(smps_pkg::SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (!trial[smps_pkg::DIVR_W]) begin
				rem_q <= trial[smps_pkg::DIVR_W-1:0];
				quo_q <= {quo_q[smps_pkg::SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[smps_pkg::DIVR_W-1:0];
				quo_q <= {quo_q[smps_pkg::SUM_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: verif/scaled_matrix_product_sum_tb.sv
// ----------------------------------------------------------------------------
// Scaled matrix product sum testbench
// Loads the five matrices over the request channel, issues compute
// transactions under several matrix sizes, and compares every result
// transaction with an in-bench prediction of the scaled product sum.
// ----------------------------------------------------------------------------
module scaled_matrix_product_sum_tb;

	typedef struct {
		logic [smps_pkg::IDX_W-1:0] row;
		logic [smps_pkg::IDX_W-1:0] col;
		logic signed [smps_pkg::OUT_W-1:0] value;
		logic last;
	} elem_result_t;

	class product_scoreboard;
		int unsigned size_n;
		logic signed [15:0] store [5][64];
		elem_result_t pending [$];
		int mismatches;
		int checked;

		function new();
			size_n = 8;
			mismatches = 0;
			checked = 0;
			for (int m = 0; m < 5; m++)
				for (int e = 0; e < 64; e++)
					store[m][e] = '0;
		endfunction

		function void set_size(logic [smps_pkg::N_W-1:0] val);
			size_n = 32'(val);
		endfunction

		function logic signed [63:0] saturate(logic signed [127:0] acc);
			logic signed [127:0] hi_lim;
			logic signed [127:0] lo_lim;
			hi_lim = 128'sh7FFF_FFFF_FFFF_FFFF;
			lo_lim = -hi_lim - 1;
			if (acc > hi_lim)
				return hi_lim[63:0];
			if (acc < lo_lim)
				return lo_lim[63:0];
			return acc[63:0];
		endfunction

		function void note_request(logic [2:0] op, logic [2:0] r, logic [2:0] c,
				logic signed [15:0] v);
			int unsigned n;
			int signed lsum;
			int signed bsum;
			int signed lavg;
			int signed bavg;
			longint signed pab [64];
			longint signed plb [64];
			logic signed [127:0] acc;
			elem_result_t res;
			if (op <= smps_pkg::OP_LOAD_L) begin
				store[op][r * 8 + c] = v;
				return;
			end
			if (op != smps_pkg::OP_RUN)
				return;
			n = size_n;
			if (n < 1) n = 1;
			if (n > 8) n = 8;
			lsum = 0;
			bsum = 0;
			for (int i = 0; i < n; i++)
				for (int j = 0; j < n; j++) begin
					bsum += int'(store[smps_pkg::OP_LOAD_B][i * 8 + j]);
					if (j < i) lsum += int'(store[smps_pkg::OP_LOAD_L][i * 8 + j]);
				end
			lavg = lsum / int'(n * n);
			bavg = bsum / int'(n * n);
			for (int i = 0; i < n; i++)
				for (int j = 0; j < n; j++) begin
					pab[i * 8 + j] = 0;
					plb[i * 8 + j] = 0;
					for (int k = 0; k < n; k++) begin
						longint signed b;
						b = longint'(store[smps_pkg::OP_LOAD_B][k * 8 + j]);
						pab[i * 8 + j] += longint'(lavg) *
							longint'(store[smps_pkg::OP_LOAD_A][i * 8 + k]) * b;
						if (k <= i)
							plb[i * 8 + j] += longint'(bavg) *
								longint'(store[smps_pkg::OP_LOAD_L][i * 8 + k]) * b;
					end
				end
			for (int i = 0; i < n; i++)
				for (int j = 0; j < n; j++) begin
					acc = '0;
					for (int k = 0; k < n; k++) begin
						acc += 128'(signed'(pab[i * 8 + k])) *
							128'(signed'(store[smps_pkg::OP_LOAD_C][k * 8 + j]));
						acc += 128'(signed'(plb[i * 8 + k])) *
							128'(signed'(store[smps_pkg::OP_LOAD_D][k * 8 + j]));
					end
					res.row = 3'(i);
					res.col = 3'(j);
					res.value = saturate(acc);
					res.last = (i == n - 1 && j == n - 1);
					pending.push_back(res);
				end
		endfunction

		function void check_result(logic [2:0] r, logic [2:0] c, logic signed [63:0] v,
				logic l);
			elem_result_t exp_res;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result transaction: row %0d col %0d value %0d",
						r, c, v);
				return;
			end
			exp_res = pending.pop_front();
			if (exp_res.row !== r || exp_res.col !== c || exp_res.value !== v
					|| exp_res.last !== l) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch: expected (%0d,%0d) %0d last %0b, got (%0d,%0d) %0d last %0b",
						exp_res.row, exp_res.col, exp_res.value, exp_res.last, r, c, v, l);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycles;
	int   computes;
	bit   quiet;
	int   written [5];
	product_scoreboard board;

	smps_req_if req();
	smps_rsp_if rsp();
	smps_cfg_if cfg();

	scaled_matrix_product_sum dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (req.valid && req.ready)
			board.note_request(req.opcode, req.row_index, req.col_index, req.elem_value);
		if (rsp.valid && rsp.ready)
			board.check_result(rsp.out_row, rsp.out_col, rsp.out_value, rsp.last);
		if (cfg.valid && cfg.ready)
			board.set_size(cfg.data);
	end

	always @(negedge clk) begin
		if (!arst_n)
			rsp.ready <= 1'b0;
		else
			rsp.ready <= quiet || ($urandom_range(99) >= 19);
	end

	task automatic send(logic [2:0] op, logic [2:0] r, logic [2:0] c, logic signed [15:0] v);
		while (!quiet && $urandom_range(99) < 19) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.opcode <= op;
		req.row_index <= r;
		req.col_index <= c;
		req.elem_value <= v;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		@(negedge clk);
		if (op <= smps_pkg::OP_LOAD_L) written[op]++;
		if (op == smps_pkg::OP_RUN) computes++;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic set_size(logic [smps_pkg::N_W-1:0] val);
		drain();
		cfg.valid <= 1'b1;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic signed [15:0] rand_elem();
		case ($urandom_range(5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'(signed'($urandom_range(512)) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	// Every element that a full-size compute reads is written; L only on and
	// below its diagonal.
	task automatic load_all(logic signed [15:0] ev);
		for (int m = 0; m <= smps_pkg::OP_LOAD_L; m++)
			for (int r = 0; r < 8; r++)
				for (int c = 0; c < 8; c++)
					if (!(m == smps_pkg::OP_LOAD_L && c > r))
						send(m[2:0], r[2:0], c[2:0], ev);
	endtask

	initial begin
		logic [smps_pkg::N_W-1:0] sizes [3];
		board = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cycles = 0;
		computes = 0;
		quiet = 1'b0;
		req.valid = 1'b0;
		req.opcode = smps_pkg::OP_LOAD_A;
		req.row_index = '0;
		req.col_index = '0;
		req.elem_value = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		rsp.ready = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		quiet = 1'b1;
		load_all(16'sh7FFF);
		send(smps_pkg::OP_RUN, 3'd7, 3'd7, 16'sh7FFF);
		send(3'd6, 3'd1, 3'd2, 16'sh1234);
		send(3'd7, 3'd5, 3'd6, 16'shEDCB);
		quiet = 1'b0;
		set_size(4'd15);
		send(smps_pkg::OP_RUN, 3'd0, 3'd0, '0);
		set_size(4'd0);
		send(smps_pkg::OP_RUN, 3'd0, 3'd0, '0);

		sizes = '{4'd2, 4'd5, 4'd3};
		for (int ph = 0; ph < 3; ph++) begin
			set_size(sizes[ph]);
			for (int t = 0; t < 5; t++) begin
				case ($urandom_range(9))
					0: send(smps_pkg::OP_RUN, 3'($urandom), 3'($urandom), 16'($urandom));
					1: send(3'($urandom_range(7, 6)), 3'($urandom), 3'($urandom),
						16'($urandom));
					default: send(3'($urandom_range(4)), 3'($urandom), 3'($urandom),
						rand_elem());
				endcase
			end
			send(smps_pkg::OP_RUN, '0, '0, '0);
		end

		drain();
		$display("Ran %0d computes at full, clamped and small sizes; %0d results checked.",
			computes, board.checked);
		$display("Loads per matrix A/B/C/D/L: %0d %0d %0d %0d %0d",
			written[0], written[1], written[2], written[3], written[4]);
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
